>>> rtl/kdhc_pkg.sv
// Package for the key debounce and hold classifier.
// Holds button state codes, register indexes, reset values and the config struct.
// No dependencies.
package kdhc_pkg;

   localparam int KEY_W         = 16;
   localparam int RUN_W         = 9;
   localparam int LIMIT_W       = 8;
   localparam int THR_W         = 16;
   localparam int CLASS_W       = 2;
   localparam int NUM_CLASSES   = 4;
   localparam int OUT_BUTTONS   = 18;
   localparam int STATE_W       = 3;
   localparam int STATES_W      = STATE_W * OUT_BUTTONS;
   localparam int CLASS_MAP_W   = CLASS_W * OUT_BUTTONS;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = CLASS_MAP_W;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = STATES_W + OUT_BUTTONS;

   localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

   typedef enum logic [STATE_W-1:0] {
      BTN_UP         = 3'd0,
      BTN_PRESS      = 3'd1,
      BTN_SHORT_DOWN = 3'd2,
      BTN_DOWN       = 3'd3,
      BTN_RELEASE    = 3'd4
   } btn_state_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_THR0      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_THR1      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_THR2      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_THR3      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_MAP      = 3'd5;

   localparam logic [LIMIT_W-1:0]     RST_DEBOUNCE_LIMIT = 8'd30;
   localparam logic [THR_W-1:0]       RST_HOLD_THR0      = 16'd300;
   localparam logic [THR_W-1:0]       RST_HOLD_THR1      = 16'd50;
   localparam logic [THR_W-1:0]       RST_HOLD_THR2      = 16'd150;
   localparam logic [THR_W-1:0]       RST_HOLD_THR3      = 16'd100;
   localparam logic [CLASS_MAP_W-1:0] RST_CLASS_MAP      = 36'hF00095500;

   typedef struct packed {
      logic [CLASS_MAP_W-1:0]                class_map;
      logic [NUM_CLASSES-1:0][THR_W-1:0]     hold_thr;
      logic [LIMIT_W-1:0]                    debounce_limit;
   } cfg_type;

endpackage

>>> rtl/kdhc_csr.sv
// Configuration registers for the key debounce and hold classifier.
// Depends on kdhc_pkg for register indexes, reset values and cfg_type.
module kdhc_csr
   import kdhc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_LIMIT: cfg_in.debounce_limit = csr_wdata[LIMIT_W-1:0];
            CSR_HOLD_THR0:      cfg_in.hold_thr[0]    = csr_wdata[THR_W-1:0];
            CSR_HOLD_THR1:      cfg_in.hold_thr[1]    = csr_wdata[THR_W-1:0];
            CSR_HOLD_THR2:      cfg_in.hold_thr[2]    = csr_wdata[THR_W-1:0];
            CSR_HOLD_THR3:      cfg_in.hold_thr[3]    = csr_wdata[THR_W-1:0];
            CSR_CLASS_MAP:      cfg_in.class_map      = csr_wdata[CLASS_MAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_limit <= RST_DEBOUNCE_LIMIT;
         cfg_ff.hold_thr[0]    <= RST_HOLD_THR0;
         cfg_ff.hold_thr[1]    <= RST_HOLD_THR1;
         cfg_ff.hold_thr[2]    <= RST_HOLD_THR2;
         cfg_ff.hold_thr[3]    <= RST_HOLD_THR3;
         cfg_ff.class_map      <= RST_CLASS_MAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/kdhc_lane.sv
// One button lane: saturating run counter, debounce compare and hold classifier.
// Depends on kdhc_pkg for btn_state_type and counter widths.
module kdhc_lane
   import kdhc_pkg::*;
#(
   parameter int HOLD_COUNT_BITS = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               raw,
   input  logic [LIMIT_W-1:0] debounce_limit,
   input  logic [THR_W-1:0]   hold_thr,
   output btn_state_type      state,
   output logic               level
);

   localparam int CMP_W = (HOLD_COUNT_BITS > THR_W) ? HOLD_COUNT_BITS : THR_W;

   logic [RUN_W-1:0]           run_ff;
   logic [RUN_W-1:0]           run_in;
   logic [HOLD_COUNT_BITS-1:0] hold_ff;
   logic [HOLD_COUNT_BITS-1:0] hold_in;
   logic [HOLD_COUNT_BITS-1:0] hold_inc;
   logic                       held_ff;
   logic                       held_in;

   always_comb begin
      if (!raw) begin
         run_in = '0;
      end else if (run_ff == RUN_MAX) begin
         run_in = run_ff;
      end else begin
         run_in = run_ff + 1'b1;
      end
      level    = run_in > RUN_W'(debounce_limit);
      hold_inc = (hold_ff == '1) ? hold_ff : hold_ff + 1'b1;
      hold_in  = hold_ff;
      held_in  = held_ff;
      if (level && !held_ff) begin
         state   = BTN_PRESS;
         hold_in = '0;
         held_in = 1'b1;
      end else if (level) begin
         hold_in = hold_inc;
         state   = (CMP_W'(hold_inc) < CMP_W'(hold_thr)) ? BTN_SHORT_DOWN : BTN_DOWN;
      end else if (held_ff) begin
         state   = BTN_RELEASE;
         held_in = 1'b0;
      end else begin
         state   = BTN_UP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= '0;
         hold_ff <= '0;
         held_ff <= 1'b0;
      end else if (accept) begin
         run_ff  <= run_in;
         hold_ff <= hold_in;
         held_ff <= held_in;
      end
   end

`ifndef SYNTHESIS
   a_press_sets_held: assert property (@(posedge clock) disable iff (reset)
      (accept && state == BTN_PRESS) |=> (held_ff && hold_ff == '0))
      else $error("press did not start a hold");
   a_release_clears_held: assert property (@(posedge clock) disable iff (reset)
      (accept && state == BTN_RELEASE) |=> (!held_ff && run_ff <= RUN_W'(debounce_limit)))
      else $error("release left the lane held");
   a_hold_advances: assert property (@(posedge clock) disable iff (reset)
      (accept && level && held_ff) |=> (held_ff && hold_ff != '0))
      else $error("hold count did not advance");
`endif

endmodule

>>> rtl/kdhc_merge.sv
// Merge stage: packs lane states and levels into one result and buffers it.
// Two-entry output buffer (main plus skid); depends on kdhc_pkg.
module kdhc_merge
   import kdhc_pkg::*;
#(
   parameter int TOTAL_BUTTONS = 18
)
(
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   input  logic [TOTAL_BUTTONS-1:0][STATE_W-1:0]   lane_states,
   input  logic [TOTAL_BUTTONS-1:0]                lane_levels,
   output logic                                    ready,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [RSP_DATA_W-1:0]                   rsp_tdata
);

   logic [STATES_W-1:0]    states_w;
   logic [OUT_BUTTONS-1:0] levels_w;
   logic [RSP_DATA_W-1:0]  result_w;

   for (genvar b = 0; b < OUT_BUTTONS; b++) begin : g_pack
      if (b < TOTAL_BUTTONS) begin : g_lane
         assign states_w[b*STATE_W +: STATE_W] = lane_states[b];
         assign levels_w[b]                    = lane_levels[b];
      end else begin : g_none
         assign states_w[b*STATE_W +: STATE_W] = '0;
         assign levels_w[b]                    = 1'b0;
      end
   end

   assign result_w = {levels_w, states_w};

   logic                  main_valid_ff;
   logic                  main_valid_in;
   logic [RSP_DATA_W-1:0] main_data_ff;
   logic [RSP_DATA_W-1:0] main_data_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   logic [RSP_DATA_W-1:0] skid_data_ff;
   logic [RSP_DATA_W-1:0] skid_data_in;
   logic                  pop;

   assign pop = main_valid_ff && rsp_tready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_data_in  = result_w;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = result_w;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign ready      = !skid_valid_ff;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;

`ifndef SYNTHESIS
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry without main entry");
   a_push_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && main_valid_ff && !pop) |=> skid_valid_ff)
      else $error("result lost while output stalled");
   a_push_fills_main: assert property (@(posedge clock) disable iff (reset)
      push |=> main_valid_ff)
      else $error("transfer accepted but no result pending");
`endif

endmodule

>>> rtl/key_debounce_hold_classifier_core.sv
// Top level of the key debounce and hold classifier: config registers,
// one lane per button and the merge stage. Depends on kdhc_pkg, kdhc_csr,
// kdhc_lane and kdhc_merge.
//
//  channel | direction | fields (low bit up)
//  req_    | in        | tdata: key_bits[15:0], btn_l_raw, btn_r_raw, zero pad
//  rsp_    | out       | tdata: button_states[53:0], debounced_bits[17:0]
//  csr_    | in        | we, index, wdata: write only, no wait
//
//  One item per cycle while req_tready is high; its result is registered in the output buffer.
//  Every lane updates its run and hold counters in the accepting cycle.
//  Reset is synchronous and clears counters, holds and registers to defaults.
//  A two-entry output buffer keeps req_tready high through one stalled result.
module key_debounce_hold_classifier_core
   import kdhc_pkg::*;
#(
   parameter int NUM_KEYS        = 16,
   parameter int NUM_BUTTONS     = 2,
   parameter int HOLD_COUNT_BITS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // key_bits[15:0], btn_l_raw[16], btn_r_raw[17], zeros[23:18]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // button_states[53:0], debounced_bits[71:54]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int TOTAL_BUTTONS = NUM_KEYS + NUM_BUTTONS;

   cfg_type                                cfg;
   logic                                   accept;
   logic [KEY_W-1:0]                       key_bits;
   logic                                   btn_l_raw;
   logic                                   btn_r_raw;
   logic [TOTAL_BUTTONS-1:0]               raw_w;
   logic [TOTAL_BUTTONS-1:0][STATE_W-1:0]  lane_states;
   logic [TOTAL_BUTTONS-1:0]               lane_levels;

   assign accept    = req_tvalid && req_tready;
   assign key_bits  = req_tdata[KEY_W-1:0];
   assign btn_l_raw = req_tdata[KEY_W];
   assign btn_r_raw = req_tdata[KEY_W+1];

   kdhc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   for (genvar b = 0; b < TOTAL_BUTTONS; b++) begin : g_lane
      logic [THR_W-1:0] thr_w;
      btn_state_type    state_w;

      if (b < NUM_KEYS) begin : g_key
         if (b < KEY_W) begin : g_in
            assign raw_w[b] = key_bits[b];
         end else begin : g_zero
            assign raw_w[b] = 1'b0;
         end
      end else if (b == NUM_KEYS) begin : g_left
         assign raw_w[b] = btn_l_raw;
      end else if (b == NUM_KEYS + 1) begin : g_right
         assign raw_w[b] = btn_r_raw;
      end else begin : g_extra
         assign raw_w[b] = 1'b0;
      end

      if (b < OUT_BUTTONS) begin : g_map
         assign thr_w = cfg.hold_thr[cfg.class_map[b*CLASS_W +: CLASS_W]];
      end else begin : g_dflt
         assign thr_w = cfg.hold_thr[0];
      end

      kdhc_lane #(
         .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
      ) u_lane (
         .clock          (clock),
         .reset          (reset),
         .accept         (accept),
         .raw            (raw_w[b]),
         .debounce_limit (cfg.debounce_limit),
         .hold_thr       (thr_w),
         .state          (state_w),
         .level          (lane_levels[b])
      );

      assign lane_states[b] = state_w;
   end

   kdhc_merge #(
      .TOTAL_BUTTONS (TOTAL_BUTTONS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .lane_states (lane_states),
      .lane_levels (lane_levels),
      .ready       (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

>>> tb/testbench.sv
// Testbench for key_debounce_hold_classifier_core: streams raw key and mouse samples,
// predicts every button state frame in a scoreboard class and checks the response stream.
// Depends on kdhc_pkg and the core RTL.
module testbench;
   import kdhc_pkg::*;

   localparam int HOLD_W      = 16;

   class button_scoreboard;
      cfg_type               cfg;
      logic [RUN_W-1:0]      run_len  [OUT_BUTTONS];
      logic [HOLD_W-1:0]     hold_len [OUT_BUTTONS];
      bit                    held     [OUT_BUTTONS];
      logic [RSP_DATA_W-1:0] expected_frames [$];
      int                    errors;

      function new();
         cfg.debounce_limit = RST_DEBOUNCE_LIMIT;
         cfg.hold_thr[0]    = RST_HOLD_THR0;
         cfg.hold_thr[1]    = RST_HOLD_THR1;
         cfg.hold_thr[2]    = RST_HOLD_THR2;
         cfg.hold_thr[3]    = RST_HOLD_THR3;
         cfg.class_map      = RST_CLASS_MAP;
         foreach (run_len[b]) begin
            run_len[b]  = '0;
            hold_len[b] = '0;
            held[b]     = 1'b0;
         end
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_DEBOUNCE_LIMIT: cfg.debounce_limit = val[LIMIT_W-1:0];
            CSR_HOLD_THR0:      cfg.hold_thr[0]    = val[THR_W-1:0];
            CSR_HOLD_THR1:      cfg.hold_thr[1]    = val[THR_W-1:0];
            CSR_HOLD_THR2:      cfg.hold_thr[2]    = val[THR_W-1:0];
            CSR_HOLD_THR3:      cfg.hold_thr[3]    = val[THR_W-1:0];
            CSR_CLASS_MAP:      cfg.class_map      = val[CLASS_MAP_W-1:0];
            default: ;
         endcase
      endfunction

      function void predict_tick(logic [OUT_BUTTONS-1:0] raw);
         logic [STATES_W-1:0]    states;
         logic [OUT_BUTTONS-1:0] levels;
         logic [CLASS_W-1:0]     cls;
         btn_state_type          st;
         states = '0;
         levels = '0;
         for (int b = 0; b < OUT_BUTTONS; b++) begin
            if (raw[b]) begin
               if (run_len[b] != RUN_MAX) run_len[b] = run_len[b] + 1'b1;
            end else begin
               run_len[b] = '0;
            end
            levels[b] = (run_len[b] > {1'b0, cfg.debounce_limit});
            cls = cfg.class_map[CLASS_W*b +: CLASS_W];
            if (levels[b] && !held[b]) begin
               st          = BTN_PRESS;
               hold_len[b] = '0;
               held[b]     = 1'b1;
            end else if (levels[b]) begin
               if (hold_len[b] != '1) hold_len[b] = hold_len[b] + 1'b1;
               st = (hold_len[b] < cfg.hold_thr[cls]) ? BTN_SHORT_DOWN : BTN_DOWN;
            end else if (held[b]) begin
               st      = BTN_RELEASE;
               held[b] = 1'b0;
            end else begin
               st = BTN_UP;
            end
            states[STATE_W*b +: STATE_W] = st;
         end
         expected_frames.push_back({levels, states});
      endfunction

      function void check_frame(logic [RSP_DATA_W-1:0] got);
         logic [RSP_DATA_W-1:0] want;
         if (expected_frames.size() == 0) begin
            errors++;
            $display("%0t: response transfer with nothing expected, got %h", $time, got);
            return;
         end
         want = expected_frames.pop_front();
         if (got[STATES_W-1:0] !== want[STATES_W-1:0]) begin
            errors++;
            $display("%0t: button_states expected %h got %h", $time,
                     want[STATES_W-1:0], got[STATES_W-1:0]);
         end
         if (got[RSP_DATA_W-1:STATES_W] !== want[RSP_DATA_W-1:STATES_W]) begin
            errors++;
            $display("%0t: debounced_bits expected %h got %h", $time,
                     want[RSP_DATA_W-1:STATES_W], got[RSP_DATA_W-1:STATES_W]);
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_DEBOUNCE_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_left = 0;
   bit seg_level [OUT_BUTTONS];
   int seg_left  [OUT_BUTTONS];

   button_scoreboard sb;

   key_debounce_hold_classifier_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready    <= 1'b0;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_frame(rsp_tdata);
   end

   task automatic send_sample(input logic [OUT_BUTTONS-1:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(raw);
      do @(posedge clock); while (!req_tready);
      sb.predict_tick(raw);
   endtask

   task automatic drive_runs(input int count, input int max_len, input int noise_pct);
      logic [OUT_BUTTONS-1:0] raw;
      for (int i = 0; i < count; i++) begin
         for (int b = 0; b < OUT_BUTTONS; b++) begin
            if (seg_left[b] == 0) begin
               seg_level[b] = $urandom_range(1);
               seg_left[b]  = $urandom_range(max_len, 1);
            end
            seg_left[b]--;
            raw[b] = seg_level[b] ^ ($urandom_range(99) < noise_pct);
         end
         send_sample(raw);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic program_regs(input logic [LIMIT_W-1:0] limit,
                               input logic [THR_W-1:0] t0, input logic [THR_W-1:0] t1,
                               input logic [THR_W-1:0] t2, input logic [THR_W-1:0] t3,
                               input logic [CLASS_MAP_W-1:0] map);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'({$urandom, $urandom});
      csr_put(CSR_DEBOUNCE_LIMIT, {junk[CSR_DATA_W-1:LIMIT_W], limit});
      csr_put(CSR_HOLD_THR0, {junk[CSR_DATA_W-1:THR_W], t0});
      csr_put(CSR_HOLD_THR1, {junk[CSR_DATA_W-1:THR_W], t1});
      csr_put(CSR_HOLD_THR2, {junk[CSR_DATA_W-1:THR_W], t2});
      csr_put(CSR_HOLD_THR3, {junk[CSR_DATA_W-1:THR_W], t3});
      csr_put(CSR_CLASS_MAP, map);
      csr_we <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset defaults, long raw runs
      drive_runs(120, 80, 3);
      settle();

      program_regs(8'd1, 16'd0, 16'd1, 16'd2, 16'd3, 36'hE4E4E4E4E);
      send_sample('0);
      repeat (7) send_sample('1);
      repeat (2) send_sample('0);
      repeat (3) send_sample(18'h2AAAA);
      repeat (3) send_sample(18'h15555);
      send_sample('1);
      repeat (2) send_sample('0);
      settle();

      program_regs(8'd0, 16'd0, 16'd2, 16'd5, 16'hFFFF, CLASS_MAP_W'({$urandom, $urandom}));
      send_idle_pct = 74;
      drive_runs(100, 10, 5);
      settle();
      send_idle_pct = 0;

      program_regs(8'd2, THR_W'($urandom_range(6)), THR_W'($urandom_range(6)),
                   THR_W'($urandom_range(6)), THR_W'($urandom_range(6)), '0);
      rsp_stall_pct = 74;
      drive_runs(100, 14, 5);
      settle();

      program_regs(8'd3, THR_W'($urandom_range(6)), THR_W'($urandom_range(6)),
                   THR_W'($urandom_range(6)), THR_W'($urandom_range(6)), '1);
      send_idle_pct = 37;
      rsp_stall_pct = 37;
      drive_runs(100, 16, 5);
      settle();
      send_idle_pct = 0;
      rsp_stall_pct = 0;

      // hold off the response side so the input backs up
      program_regs(8'd1, THR_W'($urandom_range(4)), THR_W'($urandom_range(4)),
                   THR_W'($urandom_range(4)), THR_W'($urandom_range(4)),
                   CLASS_MAP_W'({$urandom, $urandom}));
      hold_off_left <= 60;
      drive_runs(60, 8, 5);
      settle();

      // hold every button past the debounce limit under extreme thresholds
      program_regs(8'd20, 16'hFFFF, 16'd0, 16'd1, 16'hFFFE, CLASS_MAP_W'({$urandom, $urandom}));
      repeat (40) send_sample('1);
      repeat (2) send_sample('0);
      settle();

      if (sb.errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #(12 * 1000000);
      $display("testbench: FAIL");
      $finish;
   end

endmodule

>>> key_debounce_hold_classifier_core.f
rtl/kdhc_pkg.sv
rtl/kdhc_csr.sv
rtl/kdhc_lane.sv
rtl/kdhc_merge.sv
rtl/key_debounce_hold_classifier_core.sv
tb/testbench.sv
